@@ design/cwm_pkg.sv @@
// shared types, constants and helpers for the complementary window matcher
package cwm_pkg;

   localparam int MAX_PROBE   = 16;
   localparam int POS_WIDTH   = 16;
   localparam int STORE_W     = 2 * MAX_PROBE;
   localparam int LEN_W       = $clog2(MAX_PROBE + 1);
   localparam int IDX_W       = (MAX_PROBE > 1) ? $clog2(MAX_PROBE) : 1;
   localparam int QUEUE_DEPTH = 2;

   localparam int BASE_W      = 3;
   localparam int PLEN_W      = 5;
   localparam int MISS_W      = 5;
   localparam int SITE_W      = 24;
   localparam int SEQ_W       = 16;
   localparam int BASES_W     = 32;
   localparam int COUNT_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int BASES_DIGITS = BASES_W / 2;
   localparam int SITE_SUM_W  = ((POS_WIDTH > SITE_W) ? POS_WIDTH : SITE_W) + 2;

   localparam logic [SITE_W-1:0] SITE_MAX = '1;

   localparam logic [BASE_W-1:0] BASE_A = 3'd0;
   localparam logic [BASE_W-1:0] BASE_C = 3'd1;
   localparam logic [BASE_W-1:0] BASE_G = 3'd2;
   localparam logic [BASE_W-1:0] BASE_T = 3'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_PROBE_LENGTH       = 3'd0,
      CFG_ALLOWED_MISMATCHES = 3'd1,
      CFG_WOBBLE_MODE        = 3'd2,
      CFG_REVERSE_STRAND     = 3'd3,
      CFG_LEFT_COORD         = 3'd4,
      CFG_SEQ_LENGTH         = 3'd5
   } cfg_index_type;

   typedef struct packed {
      logic [PLEN_W-1:0] probe_length;
      logic [MISS_W-1:0] allowed_mismatches;
      logic              wobble_mode;
      logic              reverse_strand;
      logic [SITE_W-1:0] left_coord;
      logic [SEQ_W-1:0]  seq_length;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ERROR,
      KIND_COMPARE
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic                 last;
      logic [STORE_W-1:0]   window;
      logic [STORE_W-1:0]   probe;
      logic [POS_WIDTH-1:0] pos;
      logic [LEN_W-1:0]     len;
   } work_type;

   function automatic logic [LEN_W-1:0] eff_len(input logic [PLEN_W-1:0] plen);
      logic [LEN_W-1:0] result;
      if (plen == '0) begin
         result = LEN_W'(1);
      end else if (32'(plen) > MAX_PROBE) begin
         result = LEN_W'(MAX_PROBE);
      end else begin
         result = LEN_W'(plen);
      end
      return result;
   endfunction

endpackage

@@ design/cwm_intf.sv @@
// request and response channel interfaces
interface cwm_req_if
   import cwm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] base;
   logic              last;

   modport source(output valid, base, last, input ready);
   modport sink(input valid, base, last, output ready);
endinterface

interface cwm_rsp_if
   import cwm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [SITE_W-1:0]  match_site;
   logic [BASES_W-1:0] matched_bases;
   logic [COUNT_W-1:0] match_count;
   logic               error;

   modport source(output valid, match_site, matched_bases, match_count, error, input ready);
   modport sink(input valid, match_site, matched_bases, match_count, error, output ready);
endinterface

@@ design/cwm_front.sv @@
// front end: takes bases, builds probe and window, classifies each transfer
module cwm_front
   import cwm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   cwm_req_if.sink  req,
   input  logic     queue_full,
   output logic     push,
   output work_type push_item
);

   logic [STORE_W-1:0]   probe_ff, probe_in;
   logic [STORE_W-1:0]   window_ff, window_in;
   logic [POS_WIDTH-1:0] position_ff, position_in;
   logic                 error_seen_ff, error_seen_in;
   logic [LEN_W-1:0]     len;
   logic [LEN_W:0]       thresh;
   logic [STORE_W-1:0]   window_shift;
   logic                 accept;

   assign req.ready    = !queue_full;
   assign accept       = req.valid && req.ready;
   assign len          = eff_len(cfg.probe_length);
   assign thresh       = {len, 1'b0} - (LEN_W+1)'(1);
   assign window_shift = (window_ff << 2) | STORE_W'(req.base[1:0]);

   always_comb begin
      probe_in       = probe_ff;
      window_in      = window_ff;
      position_in    = position_ff;
      error_seen_in  = error_seen_ff;
      push_item.kind   = KIND_NONE;
      push_item.last   = req.last;
      push_item.window = window_shift;
      push_item.probe  = probe_ff;
      push_item.pos    = position_ff;
      push_item.len    = len;
      if (accept && !error_seen_ff) begin
         if (req.base > BASE_T) begin
            error_seen_in  = 1'b1;
            push_item.kind = KIND_ERROR;
         end else begin
            if (position_ff < POS_WIDTH'(len)) begin
               probe_in = (probe_ff << 2) | STORE_W'(req.base[1:0]);
            end
            window_in = window_shift;
            if (position_ff >= POS_WIDTH'(thresh)) begin
               push_item.kind = KIND_COMPARE;
            end
            if (position_ff != '1) begin
               position_in = position_ff + 1'b1;
            end
         end
      end
      if (accept && req.last) begin
         probe_in      = '0;
         window_in     = '0;
         position_in   = '0;
         error_seen_in = 1'b0;
      end
   end

   assign push = accept && ((push_item.kind != KIND_NONE) || req.last);

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff      <= '0;
         window_ff     <= '0;
         position_ff   <= '0;
         error_seen_ff <= 1'b0;
      end else begin
         probe_ff      <= probe_in;
         window_ff     <= window_in;
         position_ff   <= position_in;
         error_seen_ff <= error_seen_in;
      end
   end

endmodule

@@ design/cwm_queue.sv @@
// short work queue between front and back end
module cwm_queue
   import cwm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output work_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/cwm_back.sv @@
// back end: window compare, mismatch count, start site and result register
module cwm_back
   import cwm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      head_valid,
   input  work_type  head,
   output logic      pop,
   cwm_rsp_if.source rsp
);

   logic [MAX_PROBE-1:0][1:0] t_dig;
   logic [MAX_PROBE-1:0]      miss_bit;
   logic [MAX_PROBE-1:0]      active;
   logic [LEN_W-1:0]          miss;
   logic [BASES_W-1:0]        bases;
   logic                      is_match;

   logic [POS_WIDTH-1:0]  start;
   logic [SITE_SUM_W-1:0] fwd_site, top, pos_next, rev_site, raw_site;
   logic [SITE_W-1:0]     site;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SITE_W-1:0]     site_ff;
   logic [BASES_W-1:0]    bases_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  error_ff;
   logic [COUNT_W-1:0]    found_count_ff, found_count_in, count_inc;
   logic                  can_load, emit;

   always_comb begin
      logic [LEN_W-1:0] idx_full;
      logic [IDX_W-1:0] idx;
      logic [1:0]       q;
      logic             ok;
      for (int k = 0; k < MAX_PROBE; k++) begin
         idx_full    = head.len - LEN_W'(1) - LEN_W'(k);
         idx         = idx_full[IDX_W-1:0];
         active[k]   = (LEN_W'(k) < head.len);
         t_dig[k]    = head.window[{idx, 1'b0} +: 2];
         q           = head.probe[2*k +: 2];
         ok          = (q == ~t_dig[k]);
         if (cfg.wobble_mode &&
             ((t_dig[k] == BASE_T[1:0] && q == BASE_G[1:0]) ||
              (t_dig[k] == BASE_G[1:0] && q == BASE_T[1:0]))) begin
            ok = 1'b1;
         end
         miss_bit[k] = active[k] && !ok;
      end
   end

   always_comb begin
      miss  = '0;
      bases = '0;
      for (int k = 0; k < MAX_PROBE; k++) begin
         miss = miss + LEN_W'(miss_bit[k]);
         if (k < BASES_DIGITS && active[k]) begin
            bases[2*k +: 2] = t_dig[k];
         end
      end
   end

   assign is_match = (32'(miss) <= 32'(cfg.allowed_mismatches));

   assign start    = head.pos - POS_WIDTH'(head.len) + 1'b1;
   assign fwd_site = SITE_SUM_W'(cfg.left_coord) + SITE_SUM_W'(start);
   assign top      = SITE_SUM_W'(cfg.left_coord) + SITE_SUM_W'(cfg.seq_length);
   assign pos_next = SITE_SUM_W'(head.pos) + SITE_SUM_W'(1);
   assign rev_site = (top >= pos_next) ? top - pos_next : '0;
   assign raw_site = cfg.reverse_strand ? rev_site : fwd_site;
   assign site     = (raw_site > SITE_SUM_W'(SITE_MAX)) ? SITE_MAX : raw_site[SITE_W-1:0];

   assign can_load  = !rsp_valid_ff || rsp.ready;
   assign pop       = head_valid && can_load;
   assign emit      = pop && ((head.kind == KIND_ERROR) ||
                              (head.kind == KIND_COMPARE && is_match));
   assign count_inc = (found_count_ff == '1) ? found_count_ff : found_count_ff + 1'b1;

   always_comb begin
      found_count_in = found_count_ff;
      if (pop && head.kind == KIND_COMPARE && is_match) begin
         found_count_in = count_inc;
      end
      if (pop && head.last) begin
         found_count_in = '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         found_count_ff <= '0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         found_count_ff <= found_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (head.kind == KIND_ERROR) begin
            site_ff  <= '0;
            bases_ff <= '0;
            count_ff <= found_count_ff;
            error_ff <= 1'b1;
         end else begin
            site_ff  <= site;
            bases_ff <= bases;
            count_ff <= count_inc;
            error_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.match_site    = site_ff;
   assign rsp.matched_bases = bases_ff;
   assign rsp.match_count   = count_ff;
   assign rsp.error         = error_ff;

endmodule

@@ design/complementary_window_match.sv @@
// top level: complementary window matcher with configuration registers
// one base per cycle sustained while the work queue is not full; the result of a base
// is held in the work queue, then compared and loaded into the response register
// the compare and mismatch count over the whole window are combinational in the back end
// synchronous active-high reset clears sequence state, queue and response valid,
// and loads the register defaults
module complementary_window_match
   import cwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cwm_req_if.sink               req_channel,
   cwm_rsp_if.source             rsp_channel,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     push, queue_full, pop, head_valid;
   work_type push_item, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (cfg_index_type'(csr_index))
            CFG_PROBE_LENGTH:       cfg_in.probe_length = csr_write_data[PLEN_W-1:0];
            CFG_ALLOWED_MISMATCHES: cfg_in.allowed_mismatches = csr_write_data[MISS_W-1:0];
            CFG_WOBBLE_MODE:        cfg_in.wobble_mode = csr_write_data[0];
            CFG_REVERSE_STRAND:     cfg_in.reverse_strand = csr_write_data[0];
            CFG_LEFT_COORD:         cfg_in.left_coord = csr_write_data[SITE_W-1:0];
            CFG_SEQ_LENGTH:         cfg_in.seq_length = csr_write_data[SEQ_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.probe_length       <= PLEN_W'(8);
         cfg_ff.allowed_mismatches <= '0;
         cfg_ff.wobble_mode        <= 1'b0;
         cfg_ff.reverse_strand     <= 1'b0;
         cfg_ff.left_coord         <= SITE_W'(1);
         cfg_ff.seq_length         <= SEQ_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_channel),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   cwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   cwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_channel)
   );

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_channel.valid)
      else $error("response valid after reset");

   a_error_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && rsp_channel.error) |->
         (rsp_channel.match_site == '0 && rsp_channel.matched_bases == '0))
      else $error("error transfer with nonzero site or bases");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && !rsp_channel.error) |-> (rsp_channel.match_count != '0))
      else $error("match transfer with zero count");
`endif

endmodule
